// ===== rtl/ssc_pkg.sv =====
// Shared constants, types and the letter-folding function of the substring search stream.
`timescale 1ns / 1ps
package ssc_pkg;

   localparam int MAX_PATTERN    = 8;
   localparam int POSITION_BITS  = 16;
   localparam int BYTE_BITS      = 8;
   localparam int LEN_BITS       = 4;
   localparam int MATCH_BITS     = 16;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 64;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_PATTERN_BYTES  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PATTERN_LENGTH = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_IGNORE_CASE    = 2'd2;

   typedef logic [BYTE_BITS-1:0]     byte_type;
   typedef logic [POSITION_BITS-1:0] position_type;
   typedef logic [LEN_BITS-1:0]      length_type;
   typedef logic [MATCH_BITS-1:0]    match_type;

   typedef struct packed {
      logic shift;
      logic clear;
      logic in_use;
      logic ignore_case;
   } cell_ctrl_type;

   function automatic byte_type fold_byte(input byte_type c, input logic fold);
      byte_type r;
      r = c;
      if (fold && c >= 8'h41 && c <= 8'h5A) begin
         r = c + 8'h20;
      end
      return r;
   endfunction

endpackage

// ===== rtl/ssc_stream_if.sv =====
// Valid/ready channel interfaces for the request and response beats.
`timescale 1ns / 1ps
interface ssc_req_if;
   logic                valid;
   logic                ready;
   ssc_pkg::byte_type   text_byte;
   logic                end_of_text;

   modport source (output valid, output text_byte, output end_of_text, input ready);
   modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface ssc_rsp_if;
   logic                valid;
   logic                ready;
   logic                match_found;
   ssc_pkg::match_type  match_start;
   logic                text_done;

   modport source (output valid, output match_found, output match_start, output text_done,
                   input ready);
   modport sink   (input valid, input match_found, input match_start, input text_done,
                   output ready);
endinterface

// ===== rtl/substring_search_stream_core.sv =====
// Streaming first-occurrence substring search over a row of window cells.
// Text arrives one byte per request beat (text_byte, end_of_text); every request beat
// yields exactly one response beat (match_found, match_start, text_done) in order.
// The pattern, its length and the case-folding mode are written through the csr_ port
// and are meant to be changed only while no beat is in flight.
// A row of MAX_PATTERN cells holds the most recent bytes; each cell compares the byte
// entering it with its pattern character, so the whole window is checked as the byte
// is taken. The response beat is registered from its request beat, and one byte is taken
// in every cycle while rsp_chan.ready is high. The response register is the only buffer:
// while a response waits to be taken, req_chan.ready stays low; it rises again in the
// cycle the response beat completes, so a stalled receiver holds the block without
// losing a beat. Synchronous reset clears the window, byte count, match latch, registers
// and any pending response. A beat marked end_of_text returns its result and then clears
// the window, count and latch for the next text; the registers are kept.
`timescale 1ns / 1ps
module substring_search_stream_core (
   input  logic                                   clock,
   input  logic                                   reset,
   ssc_req_if.sink                                req_chan,
   ssc_rsp_if.source                              rsp_chan,
   input  logic                                   csr_we,
   input  logic [ssc_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [ssc_pkg::CSR_DATA_BITS-1:0]      csr_wdata
);

   localparam int MP = ssc_pkg::MAX_PATTERN;

   logic [ssc_pkg::CSR_DATA_BITS-1:0] pattern_bytes_ff;
   ssc_pkg::length_type               pattern_length_ff;
   logic                              ignore_case_ff;

   ssc_pkg::position_type pos_ff, pos_in;
   logic                  found_ff, found_in;
   ssc_pkg::position_type offset_ff, offset_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_found_ff, rsp_found_in;
   ssc_pkg::match_type rsp_start_ff, rsp_start_in;
   logic               rsp_done_ff, rsp_done_in;

   logic                accept;
   ssc_pkg::length_type len_c;
   ssc_pkg::byte_type [MP-1:0] pat_arr;
   ssc_pkg::byte_type [MP-1:0] pchar;
   ssc_pkg::byte_type [MP:0]   chain;
   logic [MP-1:0]              hits;
   ssc_pkg::cell_ctrl_type [MP-1:0] ctrl;
   logic                  match_now;
   ssc_pkg::position_type new_offset;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept = req_chan.valid && req_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_bytes_ff  <= '0;
         pattern_length_ff <= '0;
         ignore_case_ff    <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            ssc_pkg::CSR_PATTERN_BYTES: begin
               pattern_bytes_ff <= csr_wdata;
            end
            ssc_pkg::CSR_PATTERN_LENGTH: begin
               pattern_length_ff <= csr_wdata[ssc_pkg::LEN_BITS-1:0];
            end
            ssc_pkg::CSR_IGNORE_CASE: begin
               ignore_case_ff <= csr_wdata[0];
            end
            default: begin
            end
         endcase
      end
   end

   assign len_c = (int'(pattern_length_ff) > MP) ? ssc_pkg::length_type'(MP)
                                                 : pattern_length_ff;
   assign pat_arr = pattern_bytes_ff[MP*ssc_pkg::BYTE_BITS-1:0];

   always_comb begin
      for (int j = 0; j < MP; j++) begin
         pchar[j] = '0;
         for (int k = 0; k < MP; k++) begin
            if (k == int'(len_c) - 1 - j) begin
               pchar[j] = pat_arr[k];
            end
         end
         ctrl[j].shift       = accept;
         ctrl[j].clear       = req_chan.end_of_text;
         ctrl[j].in_use      = j < int'(len_c);
         ctrl[j].ignore_case = ignore_case_ff;
      end
   end

   assign chain[0] = req_chan.text_byte;

   for (genvar g = 0; g < MP; g++) begin : g_cell
      ssc_cell u_cell (
         .clock        (clock),
         .reset        (reset),
         .ctrl         (ctrl[g]),
         .byte_in      (chain[g]),
         .pattern_char (pchar[g]),
         .byte_out     (chain[g+1]),
         .hit          (hits[g])
      );
   end

   // An empty pattern always starts at offset zero.
   assign pos_in = (pos_ff == '1) ? pos_ff : pos_ff + 1'b1;
   assign new_offset = (len_c == '0) ? '0 : pos_in - ssc_pkg::position_type'(len_c);
   assign match_now = !found_ff &&
                      ((len_c == '0) ||
                       ((pos_in >= ssc_pkg::position_type'(len_c)) && (&hits)));

   always_comb begin
      found_in     = found_ff;
      offset_in    = offset_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_found_in = rsp_found_ff;
      rsp_start_in = rsp_start_ff;
      rsp_done_in  = rsp_done_ff;
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (accept) begin
         rsp_valid_in = 1'b1;
         rsp_found_in = found_ff || match_now;
         rsp_done_in  = req_chan.end_of_text;
         if (match_now) begin
            rsp_start_in = ssc_pkg::match_type'(new_offset);
            found_in     = 1'b1;
            offset_in    = new_offset;
         end else if (found_ff) begin
            rsp_start_in = ssc_pkg::match_type'(offset_ff);
         end else begin
            rsp_start_in = '0;
         end
         if (req_chan.end_of_text) begin
            found_in  = 1'b0;
            offset_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         found_ff     <= 1'b0;
         offset_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            pos_ff <= req_chan.end_of_text ? '0 : pos_in;
         end
         found_ff     <= found_in;
         offset_ff    <= offset_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_found_ff <= rsp_found_in;
      rsp_start_ff <= rsp_start_in;
      rsp_done_ff  <= rsp_done_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.match_found = rsp_found_ff;
   assign rsp_chan.match_start = rsp_start_ff;
   assign rsp_chan.text_done   = rsp_done_ff;

endmodule

// ===== rtl/ssc_cell.sv =====
// One window cell: holds a text byte, passes it on and compares the incoming byte.
`timescale 1ns / 1ps
module ssc_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  ssc_pkg::cell_ctrl_type ctrl,
   input  ssc_pkg::byte_type      byte_in,
   input  ssc_pkg::byte_type      pattern_char,
   output ssc_pkg::byte_type      byte_out,
   output logic                   hit
);

   ssc_pkg::byte_type win_ff;
   ssc_pkg::byte_type win_in;

   always_comb begin
      win_in = win_ff;
      if (ctrl.shift) begin
         win_in = ctrl.clear ? '0 : byte_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff <= '0;
      end else begin
         win_ff <= win_in;
      end
   end

   assign byte_out = win_ff;
   assign hit = !ctrl.in_use ||
                (ssc_pkg::fold_byte(byte_in, ctrl.ignore_case) ==
                 ssc_pkg::fold_byte(pattern_char, ctrl.ignore_case));

endmodule

// ===== rtl/ssc_checker.sv =====
// Port-level assertions for the substring search stream core, bound to the top level.
`timescale 1ns / 1ps
module ssc_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               req_end_of_text,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic               rsp_match_found,
   input ssc_pkg::match_type rsp_match_start,
   input logic               rsp_text_done
);

   property p_rsp_hold;
      @(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_match_found) &&
                                  $stable(rsp_match_start) && $stable(rsp_text_done);
   endproperty
   a_rsp_hold: assert property (p_rsp_hold) else $error("response beat changed while stalled");

   property p_no_overrun;
      @(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready;
   endproperty
   a_no_overrun: assert property (p_no_overrun) else $error("request taken over a held response");

   property p_one_cycle;
      @(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid && (rsp_text_done == $past(req_end_of_text));
   endproperty
   a_one_cycle: assert property (p_one_cycle) else $error("response beat missing or mismatched");

   property p_start_zero;
      @(posedge clock) disable iff (reset)
      rsp_valid && !rsp_match_found |-> rsp_match_start == '0;
   endproperty
   a_start_zero: assert property (p_start_zero) else $error("start offset without a match");

endmodule

bind substring_search_stream_core ssc_checker u_ssc_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_chan.valid),
   .req_ready       (req_chan.ready),
   .req_end_of_text (req_chan.end_of_text),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_match_found (rsp_chan.match_found),
   .rsp_match_start (rsp_chan.match_start),
   .rsp_text_done   (rsp_chan.text_done)
);

// ===== dv/tb_substring_search_stream_core.sv =====
// Self-checking testbench for the streaming substring search core.
`timescale 1ns / 1ps
module tb_substring_search_stream_core;
   import ssc_pkg::*;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNUSED_INDEX = 2'd3;

   typedef struct packed {
      logic      match_found;
      match_type match_start;
      logic      text_done;
   } search_result_type;

   logic clock;
   logic reset;
   logic                      csr_we;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_wdata;

   ssc_req_if req_chan ();
   ssc_rsp_if rsp_chan ();

   substring_search_stream_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Shadow copy of the registers and of the search state.
   logic [CSR_DATA_BITS-1:0] shadow_pattern;
   length_type               shadow_length;
   logic                     shadow_fold;
   byte_type                 recent_bytes [MAX_PATTERN];
   position_type             text_position;
   logic                     match_latched;
   position_type             latched_offset;

   search_result_type pending_results [$];

   int send_gap_pct;
   int recv_stall_pct;
   int error_count;
   int beats_taken;
   int texts_closed;
   int reg_writes;
   int results_checked;

   initial begin
      clock = 1'b0;
   end

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic byte_type lower_letter(input byte_type c, input logic enable);
      byte_type r;
      r = c;
      if (enable && c >= 8'h41 && c <= 8'h5A) begin
         r = c | 8'h20;
      end
      return r;
   endfunction

   function automatic void clear_search();
      for (int i = 0; i < MAX_PATTERN; i++) begin
         recent_bytes[i] = '0;
      end
      text_position  = '0;
      match_latched  = 1'b0;
      latched_offset = '0;
   endfunction

   function automatic search_result_type search_next_byte(input byte_type b, input logic last);
      search_result_type r;
      int   used;
      logic same;
      used = (shadow_length > MAX_PATTERN) ? MAX_PATTERN : int'(shadow_length);
      for (int i = MAX_PATTERN - 1; i > 0; i--) begin
         recent_bytes[i] = recent_bytes[i-1];
      end
      recent_bytes[0] = b;
      if (text_position != '1) begin
         text_position = text_position + 1'b1;
      end
      if (!match_latched) begin
         if (used == 0) begin
            match_latched  = 1'b1;
            latched_offset = '0;
         end else if (int'(text_position) >= used) begin
            same = 1'b1;
            for (int i = 0; i < used; i++) begin
               if (lower_letter(shadow_pattern[8*i +: 8], shadow_fold) !=
                   lower_letter(recent_bytes[used-1-i], shadow_fold)) begin
                  same = 1'b0;
               end
            end
            if (same) begin
               match_latched  = 1'b1;
               latched_offset = text_position - position_type'(used);
            end
         end
      end
      r.match_found = match_latched;
      r.match_start = match_latched ? match_type'(latched_offset) : '0;
      r.text_done   = last;
      if (last) begin
         clear_search();
      end
      return r;
   endfunction

   always @(posedge clock) begin : search_scoreboard
      search_result_type want;
      if (reset) begin
         shadow_pattern = '0;
         shadow_length  = '0;
         shadow_fold    = 1'b0;
         clear_search();
         pending_results.delete();
      end else begin
         if (csr_we) begin
            reg_writes++;
            case (csr_index)
               CSR_PATTERN_BYTES:  shadow_pattern = csr_wdata;
               CSR_PATTERN_LENGTH: shadow_length  = csr_wdata[LEN_BITS-1:0];
               CSR_IGNORE_CASE:    shadow_fold    = csr_wdata[0];
               default: ;
            endcase
         end
         if (req_chan.valid && req_chan.ready) begin
            pending_results.push_back(search_next_byte(req_chan.text_byte,
                                                       req_chan.end_of_text));
            beats_taken++;
            if (req_chan.end_of_text) begin
               texts_closed++;
            end
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (pending_results.size() == 0) begin
               $display("%0t: response beat with no request outstanding, actual %h %h %h",
                        $time, rsp_chan.match_found, rsp_chan.match_start,
                        rsp_chan.text_done);
               error_count++;
            end else begin
               want = pending_results.pop_front();
               results_checked++;
               if (rsp_chan.match_found !== want.match_found) begin
                  $display("%0t: match_found expected %0d actual %0d", $time,
                           want.match_found, rsp_chan.match_found);
                  error_count++;
               end
               if (rsp_chan.match_start !== want.match_start) begin
                  $display("%0t: match_start expected %0d actual %0d", $time,
                           want.match_start, rsp_chan.match_start);
                  error_count++;
               end
               if (rsp_chan.text_done !== want.text_done) begin
                  $display("%0t: text_done expected %0d actual %0d", $time,
                           want.text_done, rsp_chan.text_done);
                  error_count++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      rsp_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   task automatic send_byte(input byte_type b, input logic last);
      if ($urandom_range(99) < send_gap_pct) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.text_byte   <= b;
      req_chan.end_of_text <= last;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] index,
                            input logic [CSR_DATA_BITS-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   // Unused upper bits of the narrow registers carry noise to show they are ignored.
   task automatic set_search(input logic [CSR_DATA_BITS-1:0] pattern, input length_type len,
                             input logic fold);
      logic [CSR_DATA_BITS-1:0] noise;
      wait_drained();
      noise = {$urandom(), $urandom()};
      write_reg(CSR_PATTERN_BYTES, pattern);
      write_reg(CSR_PATTERN_LENGTH, {noise[CSR_DATA_BITS-1:LEN_BITS], len});
      write_reg(CSR_IGNORE_CASE, {noise[CSR_DATA_BITS-1:1], fold});
      csr_we <= 1'b0;
   endtask

   function automatic byte_type pick_char();
      byte_type c;
      case ($urandom_range(9))
         0: c = byte_type'($urandom());
         1: begin
            c = $urandom_range(1) ? 8'h40 : 8'h5B;
            if ($urandom_range(1)) c = c | 8'h20;
         end
         default: begin
            c = 8'h61 + byte_type'($urandom_range(2));
            if ($urandom_range(1)) c = c ^ 8'h20;
         end
      endcase
      return c;
   endfunction

   task automatic test_empty_pattern();
      set_search(64'h0, 4'd0, 1'b0);
      send_byte(8'h78, 1'b1);
   endtask

   task automatic test_zero_bytes();
      set_search(64'h0, 4'd2, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b1);
   endtask

   task automatic test_case_folding();
      set_search(64'h63_42_61, 4'd3, 1'b1);
      send_byte(8'h41, 1'b0);
      send_byte(8'h62, 1'b0);
      send_byte(8'h43, 1'b1);
      set_search(64'h63_42_61, 4'd3, 1'b0);
      send_byte(8'h41, 1'b0);
      send_byte(8'h62, 1'b0);
      send_byte(8'h43, 1'b1);
   endtask

   task automatic test_oversized_length();
      set_search('1, 4'd15, 1'b0);
      for (int i = 0; i < MAX_PATTERN; i++) begin
         send_byte(8'hFF, i == MAX_PATTERN - 1);
      end
   endtask

   task automatic test_later_matches();
      set_search(64'h61, 4'd1, 1'b0);
      wait_drained();
      write_reg(CSR_UNUSED_INDEX, '1);
      csr_we <= 1'b0;
      send_byte(8'h62, 1'b0);
      send_byte(8'h61, 1'b0);
      send_byte(8'h61, 1'b1);
   endtask

   task automatic test_counter_limit();
      set_search(64'h03_02_01, 4'd3, 1'b0);
      for (int i = 0; i < 65600; i++) begin
         send_byte(8'h00, 1'b0);
      end
      send_byte(8'h01, 1'b0);
      send_byte(8'h02, 1'b0);
      send_byte(8'h03, 1'b0);
      send_byte(8'h01, 1'b1);
   endtask

   // Most texts are letters drawn near the pattern with the pattern planted in them; others
   // are such letters left unplanted or raw bytes, and a few run on into the next text without an end flag.
   task automatic test_random_texts(input int gap_pct, input int stall_pct,
                                    input int item_goal);
      byte_type                 txt [80];
      logic [CSR_DATA_BITS-1:0] pat;
      length_type               plen;
      logic                     fold;
      logic                     closes;
      int                       used;
      int                       tlen;
      int                       start;
      int                       sent;
      int                       texts;
      int                       roll;
      send_gap_pct   = gap_pct;
      recv_stall_pct = stall_pct;
      sent  = 0;
      texts = 0;
      while (sent < item_goal) begin
         if (texts % 4 == 0) begin
            roll = $urandom_range(99);
            if (roll < 5) plen = 4'd0;
            else if (roll < 12) plen = length_type'($urandom_range(9, 15));
            else plen = length_type'($urandom_range(1, 8));
            for (int i = 0; i < MAX_PATTERN; i++) begin
               pat[8*i +: 8] = pick_char();
            end
            fold = $urandom_range(1);
            set_search(pat, plen, fold);
         end
         used   = (plen > MAX_PATTERN) ? MAX_PATTERN : int'(plen);
         tlen   = ($urandom_range(9) == 0) ? $urandom_range(25, 80) : $urandom_range(1, 24);
         roll   = $urandom_range(99);
         closes = ($urandom_range(9) != 0);
         for (int i = 0; i < tlen; i++) begin
            txt[i] = (roll < 20) ? byte_type'($urandom()) : pick_char();
         end
         if (roll >= 20 && roll < 85 && tlen >= used) begin
            start = $urandom_range(tlen - used);
            for (int i = 0; i < used; i++) begin
               txt[start+i] = pat[8*i +: 8];
               if (fold && $urandom_range(1) &&
                   ((txt[start+i] >= 8'h41 && txt[start+i] <= 8'h5A) ||
                    (txt[start+i] >= 8'h61 && txt[start+i] <= 8'h7A))) begin
                  txt[start+i] = txt[start+i] ^ 8'h20;
               end
            end
         end
         for (int i = 0; i < tlen; i++) begin
            send_byte(txt[i], (i == tlen - 1) && closes);
         end
         sent += tlen;
         texts++;
      end
      wait_drained();
   endtask

   initial begin
      reset                = 1'b1;
      req_chan.valid       = 1'b0;
      req_chan.text_byte   = '0;
      req_chan.end_of_text = 1'b0;
      rsp_chan.ready       = 1'b0;
      csr_we               = 1'b0;
      csr_index            = '0;
      csr_wdata            = '0;
      send_gap_pct         = 13;
      recv_stall_pct       = 77;
      error_count          = 0;
      beats_taken          = 0;
      texts_closed         = 0;
      reg_writes           = 0;
      results_checked      = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_empty_pattern();
      test_zero_bytes();
      test_case_folding();
      test_oversized_length();
      test_later_matches();
      test_random_texts(13, 77, 620);
      test_random_texts(77, 13, 620);
      test_random_texts(0, 0, 610);
      test_counter_limit();

      wait_drained();
      repeat (4) @(posedge clock);
      if (pending_results.size() != 0) begin
         $display("%0t: %0d expected responses never arrived", $time, pending_results.size());
         error_count++;
      end
      $display("Sent %0d text bytes in %0d closed texts with %0d register writes.",
               beats_taken, texts_closed, reg_writes);
      $display("Checked %0d responses, including a text past the position limit.",
               results_checked);
      if (error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      #4_000_000;
      $display("Timed out with %0d responses outstanding.", pending_results.size());
      $display("status: fail");
      $finish;
   end

endmodule
